>>> src/plo_pkg.sv
// ----------------------------------------------------------------------------
// plo_pkg: shared types and constants of the price level order queue
// Operation codes, field widths and the structs passed between the queue
// controller and its chain of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none
package plo_pkg;

   localparam int OP_W  = 2;
   localparam int ID_W  = 32;
   localparam int QTY_W = 32;
   localparam int LVL_W = 7;
   localparam int SUM_W = 38;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // one resting order as held in a slot cell
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [QTY_W-1:0] qty;
   } plo_entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             append;
      logic [ID_W-1:0]  wr_id;
      logic [QTY_W-1:0] wr_qty;
      logic [ID_W-1:0]  key;
   } plo_ctrl_type;

   // status of one cell back to the controller
   typedef struct packed {
      logic hit;
      logic last;
   } plo_stat_type;

endpackage
`default_nettype wire

>>> src/plo_if.sv
// ----------------------------------------------------------------------------
// plo_req_if / plo_rsp_if: valid-ready channels of the order queue
// Request beats carry one operation; response beats carry one step result.
// ----------------------------------------------------------------------------
`default_nettype none
interface plo_req_if;
   logic                       valid;
   logic                       ready;
   logic [plo_pkg::OP_W-1:0]   op;
   logic [plo_pkg::ID_W-1:0]   order_id;
   logic [plo_pkg::QTY_W-1:0]  order_quantity;

   modport source (output valid, op, order_id, order_quantity, input ready);
   modport sink   (input valid, op, order_id, order_quantity, output ready);
endinterface

interface plo_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic                       front_valid;
   logic [plo_pkg::ID_W-1:0]   front_id;
   logic [plo_pkg::QTY_W-1:0]  front_quantity;
   logic [plo_pkg::LVL_W-1:0]  level_count;
   logic [plo_pkg::SUM_W-1:0]  total_quantity;

   modport source (output valid, accepted, front_valid, front_id, front_quantity,
                   level_count, total_quantity, input ready);
   modport sink   (input valid, accepted, front_valid, front_id, front_quantity,
                   level_count, total_quantity, output ready);
endinterface
`default_nettype wire

>>> src/plo_cell.sv
// ----------------------------------------------------------------------------
// plo_cell: one slot of the order queue chain
// Holds one order, takes an appended order when its index equals the count,
// and during a cancel scan compares the key, then pulls in its right
// neighbor once the matching order sits at or left of it.
// ----------------------------------------------------------------------------
`default_nettype none
module plo_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plo_pkg::plo_ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic                  is_last_cell,
   input  wire logic                  token_in,
   input  wire logic                  found_in,
   input  wire plo_pkg::plo_entry_type next_entry,
   output plo_pkg::plo_entry_type     entry,
   output logic                       token_out,
   output logic                       found_out,
   output plo_pkg::plo_stat_type      stat
);
   import plo_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_INDEX);

   plo_entry_type entry_ff, entry_in;
   logic          token_ff, found_ff;
   logic          occupied, hit;

   assign occupied = (count > MY_IDX);
   assign hit      = token_ff & occupied & ~found_ff & (entry_ff.id == ctrl.key);

   // pick next slot contents: append, shift left, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append && (count == MY_IDX)) begin
         entry_in.id  = ctrl.wr_id;
         entry_in.qty = ctrl.wr_qty;
      end else if (token_ff && (found_ff || hit)) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // advance the scan token one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         found_ff <= found_in;
      end
   end

   assign stat.hit   = hit;
   assign stat.last  = token_ff & (~occupied | is_last_cell);
   assign token_out  = token_ff & ~stat.last;
   assign found_out  = found_ff | hit;
   assign entry      = entry_ff;

endmodule
`default_nettype wire

>>> src/price_level_order_queue.sv
// Sequence: append, clear and unused codes go from the request beat to state
// DONE; a cancel first scans at most min(count + 1, QUEUE_DEPTH) cells, the
// scan token walking the cell chain one slot per cycle. DONE then waits until
// the response register is free. Throughput: one item at a time; the
// next beat is taken in the cycle after the result loads, even while it waits.
// Reset: count and total clear at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
// price_level_order_queue: time-priority queue of one price level
// Controller plus a chain of slot cells. Append writes the tail cell, cancel
// runs a token down the chain that removes the oldest matching order and
// closes the gap, clear drops all orders.
// ----------------------------------------------------------------------------
`default_nettype none
module price_level_order_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   plo_req_if.sink   req_bus,
   plo_rsp_if.source rsp_bus
);
   import plo_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             acc_ff, acc_in;
   logic [ID_W-1:0]  key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff;
   logic             rsp_fv_ff;
   logic [ID_W-1:0]  rsp_id_ff;
   logic [QTY_W-1:0] rsp_qty_ff;
   logic [LVL_W-1:0] rsp_lvl_ff;
   logic [SUM_W-1:0] rsp_sum_ff;

   logic             req_fire, start_scan, any_hit, scan_done, has_room;
   logic             rsp_load;
   logic [QTY_W-1:0] hit_qty;
   logic [CNT_W+LVL_W-1:0] count_ext;
   plo_ctrl_type     ctrl;

   plo_entry_type entries [QUEUE_DEPTH];
   plo_entry_type nexts   [QUEUE_DEPTH];
   plo_stat_type  stats   [QUEUE_DEPTH];
   logic          tokens  [QUEUE_DEPTH+1];
   logic          founds  [QUEUE_DEPTH+1];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign has_room      = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign start_scan    = req_fire && (req_bus.op == OP_CANCEL);

   // load the result once the response register is free
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // broadcast append and cancel key to the cells
   assign ctrl.append = req_fire && (req_bus.op == OP_APPEND) && has_room;
   assign ctrl.wr_id  = req_bus.order_id;
   assign ctrl.wr_qty = req_bus.order_quantity;
   assign ctrl.key    = key_ff;

   assign tokens[0] = start_scan;
   assign founds[0] = 1'b0;

   // build the chain of slot cells
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g < QUEUE_DEPTH - 1) begin : g_mid
         assign nexts[g] = entries[g+1];
      end else begin : g_end
         assign nexts[g] = '0;
      end
      plo_cell #(
         .CELL_INDEX (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .count        (count_ff),
         .is_last_cell (g == QUEUE_DEPTH - 1),
         .token_in     (tokens[g]),
         .found_in     (founds[g]),
         .next_entry   (nexts[g]),
         .entry        (entries[g]),
         .token_out    (tokens[g+1]),
         .found_out    (founds[g+1]),
         .stat         (stats[g])
      );
   end

   // collect hit and end of scan from all cells
   always_comb begin
      any_hit   = 1'b0;
      scan_done = 1'b0;
      hit_qty   = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         any_hit   = any_hit | stats[i].hit;
         scan_done = scan_done | stats[i].last;
         hit_qty   = hit_qty | (entries[i].qty & {QTY_W{stats[i].hit}});
      end
   end

   // sequence the operation and update count and total
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      key_in   = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DONE;
               acc_in   = 1'b0;
               case (req_bus.op)
                  OP_APPEND: begin
                     if (has_room) begin
                        count_in = count_ff + CNT_W'(1);
                        sum_in   = sum_ff + SUM_W'(req_bus.order_quantity);
                        acc_in   = 1'b1;
                     end
                  end
                  OP_CANCEL: begin
                     key_in   = req_bus.order_id;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     sum_in   = '0;
                     acc_in   = 1'b1;
                  end
                  default: begin
                     acc_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               count_in = count_ff - CNT_W'(1);
               sum_in   = sum_ff - SUM_W'(hit_qty);
               acc_in   = 1'b1;
            end
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         acc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // hold the result beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign count_ext = {{LVL_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_acc_ff <= acc_ff;
         rsp_fv_ff  <= (count_ff != '0);
         rsp_id_ff  <= entries[0].id & {ID_W{count_ff != '0}};
         rsp_qty_ff <= entries[0].qty & {QTY_W{count_ff != '0}};
         rsp_lvl_ff <= count_ext[LVL_W-1:0];
         rsp_sum_ff <= sum_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.accepted       = rsp_acc_ff;
   assign rsp_bus.front_valid    = rsp_fv_ff;
   assign rsp_bus.front_id       = rsp_id_ff;
   assign rsp_bus.front_quantity = rsp_qty_ff;
   assign rsp_bus.level_count    = rsp_lvl_ff;
   assign rsp_bus.total_quantity = rsp_sum_ff;

endmodule
`default_nettype wire
